FILE: rtl/core/ecmr_pkg.sv
// Shared constants, codes and types of the edge coverage map recorder.
package ecmr_pkg;

   // Map geometry: 2^MAP_BITS counters of COUNT_W bits
   localparam int MAP_BITS     = 16;
   localparam int MAP_BITS_MAX = 24;
   localparam int MAP_DEPTH    = 1 << MAP_BITS;
   localparam int COUNT_W      = 8;
   localparam int ADDR_W       = 64;
   localparam int INDEX_W      = 16;
   localparam int CSR_INDEX_W  = 1;

   // Request modes
   localparam logic [1:0] MODE_EVENT = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // Map operations carried down the pipeline
   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_INC  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ALT_MODE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRY    = 1'b1;

   typedef struct packed {
      logic [1:0]          op;
      logic [MAP_BITS-1:0] idx;
      logic                started;
   } map_req_type;

   typedef struct packed {
      logic               recorded;
      logic [INDEX_W-1:0] map_index;
      logic [COUNT_W-1:0] count;
      logic               started;
   } rsp_type;

   // Low INDEX_W bits of a map index, zero-extended when the map is narrower
   function automatic logic [INDEX_W-1:0] out_index(input logic [MAP_BITS-1:0] idx);
      logic [MAP_BITS_MAX-1:0] ext;
      ext = MAP_BITS_MAX'(idx);
      return ext[INDEX_W-1:0];
   endfunction

endpackage

FILE: rtl/core/ecmr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ecmr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/ecmr_ctrl.sv
// Recording control: registers, entry match, previous location and map operation decode.
module ecmr_ctrl (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [ecmr_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [ecmr_pkg::ADDR_W-1:0]            csr_wdata,
   input  logic                                   accept,
   input  logic [1:0]                             mode,
   input  logic [ecmr_pkg::ADDR_W-1:0]            block_address,
   input  logic                                   first_in_block,
   input  logic                                   last_in_block,
   input  logic                                   is_return,
   input  logic                                   is_cond_branch,
   input  logic                                   is_indirect_call,
   input  logic                                   is_multiway_branch,
   input  logic [ecmr_pkg::INDEX_W-1:0]           read_index,
   output ecmr_pkg::map_req_type                  map_req
);
   import ecmr_pkg::*;

   logic                alt_mode_ff;
   logic [ADDR_W-1:0]   entry_ff;
   logic [MAP_BITS-1:0] prev_ff, prev_in;
   logic                rec_ff, rec_in;
   logic                seen_ff, seen_in;
   logic                pend_ff, pend_in;

   logic [MAP_BITS-1:0] block_id;
   logic [MAP_BITS-1:0] read_idx;
   logic                entry_hit;
   logic                ends_branch;

   assign block_id    = block_address[MAP_BITS:1];
   assign read_idx    = MAP_BITS'(MAP_BITS_MAX'(read_index));
   assign entry_hit   = !seen_ff && (entry_ff != '0) && (block_address == entry_ff);
   assign ends_branch = last_in_block && !is_return
                        && (is_cond_branch || is_indirect_call || is_multiway_branch);

   // Decode the request into a map operation and the next control state
   always_comb begin
      prev_in     = prev_ff;
      rec_in      = rec_ff;
      seen_in     = seen_ff;
      pend_in     = pend_ff;
      map_req.op  = OP_NONE;
      map_req.idx = '0;
      case (mode)
         MODE_START: begin
            rec_in  = 1'b1;
            prev_in = '0;
         end
         MODE_READ: begin
            map_req.op  = OP_READ;
            map_req.idx = read_idx;
         end
         MODE_EVENT: begin
            if (!alt_mode_ff) begin
               if (first_in_block) begin
                  if (!rec_ff) begin
                     if (entry_hit) begin
                        seen_in = 1'b1;
                        rec_in  = 1'b1;
                     end
                  end else begin
                     map_req.op  = OP_INC;
                     map_req.idx = prev_ff ^ block_id;
                     prev_in     = {1'b0, block_id[MAP_BITS-1:1]};
                  end
               end
            end else begin
               if (!rec_ff) begin
                  if (entry_hit) begin
                     seen_in = 1'b1;
                     rec_in  = 1'b1;
                  end
               end else begin
                  if (pend_ff) begin
                     pend_in     = 1'b0;
                     map_req.op  = OP_INC;
                     map_req.idx = prev_ff ^ block_id;
                     prev_in     = {1'b0, block_id[MAP_BITS-1:1]};
                  end
                  if (ends_branch) begin
                     pend_in = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      map_req.started = rec_in;
   end

   // Hold configuration and advance control state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         alt_mode_ff <= 1'b0;
         entry_ff    <= '0;
         prev_ff     <= '0;
         rec_ff      <= 1'b0;
         seen_ff     <= 1'b0;
         pend_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ALT_MODE: alt_mode_ff <= csr_wdata[0];
               CSR_ENTRY:    entry_ff    <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (accept) begin
            prev_ff <= prev_in;
            rec_ff  <= rec_in;
            seen_ff <= seen_in;
            pend_ff <= pend_in;
         end
      end
   end

endmodule

FILE: rtl/core/ecmr_map.sv
// Hit map: clearing pass, counter read-modify-write with bypass, result formatting.
module ecmr_map (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  ecmr_pkg::map_req_type map_req,
   output logic                  clearing,
   output logic                  rsp_valid,
   output ecmr_pkg::rsp_type     rsp
);
   import ecmr_pkg::*;

   logic                b_valid_ff;
   map_req_type         b_req_ff;
   logic                clearing_ff;
   logic [MAP_BITS-1:0] clr_addr_ff;
   logic                fwd_valid_ff;
   logic [MAP_BITS-1:0] fwd_idx_ff;
   logic [COUNT_W-1:0]  fwd_data_ff;

   logic [COUNT_W-1:0]  rd_data;
   logic [COUNT_W-1:0]  cur_count;
   logic [COUNT_W-1:0]  new_count;
   logic                do_inc;
   logic                wr_en;
   logic [MAP_BITS-1:0] wr_addr;
   logic [COUNT_W-1:0]  wr_data;

   ecmr_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (MAP_DEPTH)
   ) u_hit_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (map_req.idx),
      .rd_data (rd_data)
   );

   // Take the counter from the write made in the previous cycle when it hit the same entry
   assign cur_count = (fwd_valid_ff && (fwd_idx_ff == b_req_ff.idx)) ? fwd_data_ff : rd_data;
   assign new_count = cur_count + COUNT_W'(1);
   assign do_inc    = b_valid_ff && (b_req_ff.op == OP_INC);

   // Write port: zero fill during clearing, increment otherwise
   assign wr_en   = clearing_ff || do_inc;
   assign wr_addr = clearing_ff ? clr_addr_ff : b_req_ff.idx;
   assign wr_data = clearing_ff ? '0 : new_count;

   assign clearing  = clearing_ff;
   assign rsp_valid = b_valid_ff;

   // Format the result of the request in the read stage
   always_comb begin
      rsp.recorded  = (b_req_ff.op == OP_INC);
      rsp.map_index = (b_req_ff.op == OP_NONE) ? '0 : out_index(b_req_ff.idx);
      rsp.started   = b_req_ff.started;
      case (b_req_ff.op)
         OP_INC:  rsp.count = new_count;
         OP_READ: rsp.count = cur_count;
         default: rsp.count = '0;
      endcase
   end

   // Advance the read stage, track the last write, sweep the map after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
      end else begin
         b_valid_ff   <= accept;
         fwd_valid_ff <= do_inc;
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + MAP_BITS'(1);
            if (clr_addr_ff == '1) begin
               clearing_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      b_req_ff    <= map_req;
      fwd_idx_ff  <= b_req_ff.idx;
      fwd_data_ff <= new_count;
   end

endmodule

FILE: rtl/core/ecmr_rsp_queue.sv
// Three-entry response queue that decouples the map pipeline from a stalled receiver.
module ecmr_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ecmr_pkg::rsp_type push_data,
   input  logic              pop,
   output logic              not_empty,
   output logic [1:0]        level,
   output ecmr_pkg::rsp_type head
);
   import ecmr_pkg::*;

   localparam logic [1:0] LAST_SLOT = 2'd2;

   rsp_type    slot_ff [3];
   logic [1:0] wr_ptr_ff;
   logic [1:0] rd_ptr_ff;
   logic [1:0] level_ff;

   assign not_empty = (level_ff != 2'd0);
   assign level     = level_ff;
   assign head      = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_SLOT) ? 2'd0 : wr_ptr_ff + 2'd1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_SLOT) ? 2'd0 : rd_ptr_ff + 2'd1;
         end
         if (push && !pop) begin
            level_ff <= level_ff + 2'd1;
         end else if (pop && !push) begin
            level_ff <= level_ff - 2'd1;
         end
      end
   end

   // Store the incoming response
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/edge_coverage_map_recorder.sv
// Edge coverage map recorder: top level joining control, hit map and response queue.
//
// Requests arrive on req_* (valid/stall): instruction events, start events and
// map read-backs. Every accepted request gives exactly one response on rsp_*
// (valid/stall), in order. Configuration is written through csr_wr_en,
// csr_index and csr_wdata: index 0 selects alternative mode, index 1 the
// entry address.
// Requests pass the map read stage and then the queue on the way to rsp_*.
// Throughput: one request per cycle while req_stall is low; each edge
// counter increment is a read-modify-write over the hit map's one read port
// and one write port; a one-entry bypass serves back-to-back hits on a counter.
// Reset: control state is cleared and the hit map is swept to zero, one entry
// per cycle over all 2^MAP_BITS entries (65536 at 16 map bits). req_stall stays
// high during the sweep; configuration writes are taken throughout.
// When the receiver stalls, up to three responses are held in a queue; once
// the queue plus the request in flight fill it, req_stall rises.
module edge_coverage_map_recorder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [ecmr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ecmr_pkg::ADDR_W-1:0]       csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_mode,
   input  logic [ecmr_pkg::ADDR_W-1:0]       req_block_address,
   input  logic                              req_first_in_block,
   input  logic                              req_last_in_block,
   input  logic                              req_is_return,
   input  logic                              req_is_cond_branch,
   input  logic                              req_is_indirect_call,
   input  logic                              req_is_multiway_branch,
   input  logic [ecmr_pkg::INDEX_W-1:0]      req_read_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_recorded,
   output logic [ecmr_pkg::INDEX_W-1:0]      rsp_map_index,
   output logic [ecmr_pkg::COUNT_W-1:0]      rsp_count,
   output logic                              rsp_started
);
   import ecmr_pkg::*;

   map_req_type map_req;
   rsp_type     map_rsp;
   rsp_type     head;
   logic        accept;
   logic        clearing;
   logic        map_rsp_valid;
   logic        pop;
   logic [1:0]  level;
   logic [2:0]  pending;

   // Stall while sweeping or when the queue could not absorb another response
   assign pending   = {1'b0, level} + {2'b00, map_rsp_valid};
   assign req_stall = clearing || (pending > 3'd2);
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   ecmr_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .accept             (accept),
      .mode               (req_mode),
      .block_address      (req_block_address),
      .first_in_block     (req_first_in_block),
      .last_in_block      (req_last_in_block),
      .is_return          (req_is_return),
      .is_cond_branch     (req_is_cond_branch),
      .is_indirect_call   (req_is_indirect_call),
      .is_multiway_branch (req_is_multiway_branch),
      .read_index         (req_read_index),
      .map_req            (map_req)
   );

   ecmr_map u_map (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .map_req   (map_req),
      .clearing  (clearing),
      .rsp_valid (map_rsp_valid),
      .rsp       (map_rsp)
   );

   ecmr_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (map_rsp_valid),
      .push_data (map_rsp),
      .pop       (pop),
      .not_empty (rsp_valid),
      .level     (level),
      .head      (head)
   );

   assign rsp_recorded  = head.recorded;
   assign rsp_map_index = head.map_index;
   assign rsp_count     = head.count;
   assign rsp_started   = head.started;

endmodule
